FILE: rtl/bgc_pkg.sv
// Barrier gate controller package: state and order codes, pass structs and
// the seconds-to-milliseconds timeout threshold helper.
// No dependencies.
package bgc_pkg;

  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned THR_W    = 26;  // (65535 + 1) * 1000 fits in 26 bits

  typedef enum logic [3:0] {
    ST_INIT         = 4'd0,
    ST_CLOSED       = 4'd1,
    ST_OPEN_PULSE   = 4'd2,
    ST_OPENING      = 4'd3,
    ST_OPENING_BUSY = 4'd4,
    ST_OPEN         = 4'd5,
    ST_OPEN_BUSY    = 4'd6,
    ST_OPEN_CLEAR   = 4'd7,
    ST_CLOSE_PULSE  = 4'd8,
    ST_CLOSING      = 4'd9
  } gate_state_t;

  typedef enum logic [1:0] {
    ORD_NONE        = 2'd0,
    ORD_OPEN_AUTO   = 2'd1,
    ORD_OPEN_MANUAL = 2'd2,
    ORD_CLOSE       = 2'd3
  } order_t;

  typedef enum logic [1:0] {
    REG_RETRY_NO_LIMIT   = 2'd0,
    REG_RETRY_MOVING     = 2'd1,
    REG_OPEN_IDLE_CLOSE  = 2'd2,
    REG_OPEN_CLEAR_CLOSE = 2'd3
  } reg_index_t;

  // One timeout: enabled when the register is non-zero; fires once the
  // elapsed milliseconds reach (limit + 1) * 1000.
  typedef struct packed {
    logic             en;
    logic [THR_W-1:0] thr;
  } timeout_t;

  typedef struct packed {
    timeout_t no_limit;
    timeout_t moving;
    timeout_t idle_close;
    timeout_t clear_close;
  } timeout_set_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  web_order;
    logic        manual_open_press;
    logic        auto_open_press;
    logic        close_press;
    logic        limit_open;
    logic        limit_closed;
    logic        obstacle;
  } pass_in_t;

  typedef struct packed {
    gate_state_t state;
    logic        auto_mode;
    logic [31:0] entry_ms;
  } gate_ctx_t;

  typedef struct packed {
    gate_ctx_t ctx;
    logic      pulse;
  } pass_out_t;

  function automatic logic [THR_W-1:0] thr_of(input logic [15:0] limit_s);
    logic [16:0] plus1;
    logic [26:0] prod;
    plus1 = {1'b0, limit_s} + 17'd1;
    prod  = 27'(plus1) * 27'(MS_PER_S);
    return prod[THR_W-1:0];
  endfunction

endpackage

FILE: rtl/bgc_if.sv
// Handshake channel interfaces of the barrier gate controller: input items,
// results and configuration writes. No dependencies.
interface bgc_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [1:0]  web_order;
  logic        manual_open_press;
  logic        auto_open_press;
  logic        close_press;
  logic        limit_open;
  logic        limit_closed;
  logic        obstacle;

  modport source(output valid, now_ms, web_order, manual_open_press, auto_open_press,
                 close_press, limit_open, limit_closed, obstacle, input ready);
  modport sink(input valid, now_ms, web_order, manual_open_press, auto_open_press,
               close_press, limit_open, limit_closed, obstacle, output ready);
endinterface

interface bgc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] gate_state;
  logic       relay_pulse;
  logic       is_closed;
  logic       auto_mode_out;

  modport source(output valid, gate_state, relay_pulse, is_closed, auto_mode_out,
                 input ready);
  modport sink(input valid, gate_state, relay_pulse, is_closed, auto_mode_out,
               output ready);
endinterface

interface bgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/bgc_step.sv
// One control pass of the barrier gate: order arbitration, mode update and a
// single machine transition with seconds-in-state timeouts.
// Depends on bgc_pkg.
module bgc_step import bgc_pkg::*; (
  input  pass_in_t     item,
  input  gate_ctx_t    ctx,
  input  timeout_set_t tmo,
  output pass_out_t    res
);

  order_t      order;
  logic        ord_open;
  logic        ord_close;
  logic        moved;
  logic        auto_n;
  gate_state_t st0;
  gate_state_t tgt;
  logic        enter;
  logic [31:0] diff;
  timeout_t    sel;
  logic        expired;
  logic        lo;
  logic        lc;
  logic        obs;

  assign lo  = item.limit_open;
  assign lc  = item.limit_closed;
  assign obs = item.obstacle;

  // Web order first, then buttons in rank order.
  always_comb begin
    order = order_t'(item.web_order);
    if (order == ORD_NONE) begin
      if (item.manual_open_press) order = ORD_OPEN_MANUAL;
      else if (item.auto_open_press) order = ORD_OPEN_AUTO;
      else if (item.close_press) order = ORD_CLOSE;
    end
  end

  assign auto_n    = (order != ORD_NONE) ? (order != ORD_OPEN_MANUAL) : ctx.auto_mode;
  assign ord_open  = ((order == ORD_OPEN_AUTO) || (order == ORD_OPEN_MANUAL)) && !lo;
  assign ord_close = (order == ORD_CLOSE) && !lc;
  assign moved     = ord_open || ord_close;
  assign st0       = ord_open ? ST_OPENING : (ord_close ? ST_CLOSING : ctx.state);

  // Pick the one timeout that the current state watches.
  always_comb begin
    case (st0)
      ST_OPEN_PULSE, ST_CLOSE_PULSE:            sel = tmo.no_limit;
      ST_OPENING, ST_OPENING_BUSY, ST_CLOSING:  sel = tmo.moving;
      ST_OPEN:                                  sel = tmo.idle_close;
      ST_OPEN_CLEAR:                            sel = tmo.clear_close;
      default:                                  sel = '0;
    endcase
  end

  // A state just entered by an order has zero elapsed time.
  assign diff    = item.now_ms - ctx.entry_ms;
  assign expired = !moved && sel.en && (diff >= {{(32-THR_W){1'b0}}, sel.thr});

  always_comb begin
    enter = 1'b0;
    tgt   = st0;
    case (st0)
      ST_INIT: begin
        enter = 1'b1;
        if (lc) tgt = ST_CLOSED;
        else if (lo) tgt = ST_OPEN;
        else tgt = ST_CLOSE_PULSE;
      end
      ST_OPEN_PULSE: begin
        if (!lo && !lc) begin
          enter = 1'b1; tgt = ST_OPENING;
        end else if (expired) begin
          enter = 1'b1; tgt = ST_OPEN_PULSE;
        end
      end
      ST_OPENING: begin
        if (lo) begin
          enter = 1'b1; tgt = ST_OPEN;
        end else if (lc) begin
          enter = 1'b1; tgt = ST_OPEN_PULSE;
        end else if (obs) begin
          enter = 1'b1; tgt = ST_OPENING_BUSY;
        end else if (expired) begin
          enter = 1'b1; tgt = ST_OPEN_PULSE;
        end
      end
      ST_OPENING_BUSY: begin
        if (lo) begin
          enter = 1'b1; tgt = ST_OPEN_BUSY;
        end else if (lc || expired) begin
          enter = 1'b1; tgt = ST_OPEN_PULSE;
        end
      end
      ST_OPEN: begin
        if (auto_n && obs) begin
          enter = 1'b1; tgt = ST_OPEN_BUSY;
        end else if (auto_n && expired) begin
          enter = 1'b1; tgt = ST_CLOSE_PULSE;
        end
      end
      ST_OPEN_BUSY: begin
        if (!obs) begin
          enter = 1'b1; tgt = auto_n ? ST_OPEN_CLEAR : ST_OPEN;
        end
      end
      ST_OPEN_CLEAR: begin
        if (obs) begin
          enter = 1'b1; tgt = ST_OPEN_BUSY;
        end else if (expired) begin
          enter = 1'b1; tgt = ST_CLOSE_PULSE;
        end
      end
      ST_CLOSE_PULSE: begin
        if (!lo && !lc) begin
          enter = 1'b1; tgt = ST_CLOSING;
        end else if (expired) begin
          enter = 1'b1; tgt = ST_CLOSE_PULSE;
        end
      end
      ST_CLOSING: begin
        if (lc) begin
          enter = 1'b1; tgt = ST_CLOSED;
        end else if (lo || expired) begin
          enter = 1'b1; tgt = ST_CLOSE_PULSE;
        end
      end
      default: begin
        enter = 1'b0;
        tgt   = st0;
      end
    endcase
  end

  assign res.ctx.state     = enter ? tgt : st0;
  assign res.ctx.auto_mode = auto_n;
  assign res.ctx.entry_ms  = (enter || moved) ? item.now_ms : ctx.entry_ms;
  assign res.pulse         = enter && ((tgt == ST_OPEN_PULSE) || (tgt == ST_CLOSE_PULSE));

endmodule

FILE: rtl/barrier_gate_controller.sv
// Barrier gate controller top level: input register, one-pass control step,
// result register and timeout configuration. Depends on bgc_pkg, bgc_if, bgc_step.
//
// Each input transfer is one control pass of the barrier machine and yields
// exactly one result transfer. The block takes one item per clock cycle when
// the result side keeps up. A taken item passes through the input register,
// then the result register, before its result is offered. While a result is
// held off, the input register keeps one more item and the input stalls.
// The one-item-per-cycle rate is set by the loop through the gate state,
// mode flag and state-entry time, which the control step reads and
// rewrites in the same cycle. Timeout registers are turned into millisecond
// thresholds as they are written, so a pass needs only one 32-bit subtract
// and compare. Write configuration only while no items are in flight. No
// start-up sweep is needed: the block is ready straight out of reset.
module barrier_gate_controller import bgc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  bgc_item_if.sink      item,
  bgc_result_if.source  result,
  bgc_cfg_if.sink       cfg
);

  // Timeout configuration, held as thresholds.
  timeout_set_t tmo;

  // Input stage
  logic     s1_valid;
  pass_in_t s1_item;

  // Machine state
  gate_ctx_t ctx;
  pass_out_t step_res;

  // Result stage
  logic        out_valid;
  gate_state_t out_state;
  logic        out_pulse;
  logic        out_auto;

  logic advance;
  logic take;

  // Advance the input stage into the result register when the latter is
  // free or being emptied this cycle.
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;
  assign take       = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo.no_limit.en    <= 1'b0;
      tmo.moving.en      <= 1'b0;
      tmo.idle_close.en  <= 1'b0;
      tmo.clear_close.en <= 1'b0;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_RETRY_NO_LIMIT: begin
          tmo.no_limit.en  <= (cfg.data != '0);
          tmo.no_limit.thr <= thr_of(cfg.data);
        end
        REG_RETRY_MOVING: begin
          tmo.moving.en  <= (cfg.data != '0);
          tmo.moving.thr <= thr_of(cfg.data);
        end
        REG_OPEN_IDLE_CLOSE: begin
          tmo.idle_close.en  <= (cfg.data != '0);
          tmo.idle_close.thr <= thr_of(cfg.data);
        end
        REG_OPEN_CLEAR_CLOSE: begin
          tmo.clear_close.en  <= (cfg.data != '0);
          tmo.clear_close.thr <= thr_of(cfg.data);
        end
        default: begin
          tmo.no_limit.en <= tmo.no_limit.en;
        end
      endcase
    end
  end

  // Capture the input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.now_ms            <= item.now_ms;
      s1_item.web_order         <= item.web_order;
      s1_item.manual_open_press <= item.manual_open_press;
      s1_item.auto_open_press   <= item.auto_open_press;
      s1_item.close_press       <= item.close_press;
      s1_item.limit_open        <= item.limit_open;
      s1_item.limit_closed      <= item.limit_closed;
      s1_item.obstacle          <= item.obstacle;
    end
  end

  bgc_step u_step (
    .item (s1_item),
    .ctx  (ctx),
    .tmo  (tmo),
    .res  (step_res)
  );

  // Commit the pass: machine state and result register move together.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state     <= ST_INIT;
      ctx.auto_mode <= 1'b1;
      ctx.entry_ms  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        ctx       <= step_res.ctx;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= step_res.ctx.state;
      out_pulse <= step_res.pulse;
      out_auto  <= step_res.ctx.auto_mode;
    end
  end

  assign result.valid         = out_valid;
  assign result.gate_state    = out_state;
  assign result.relay_pulse   = out_pulse;
  assign result.is_closed     = (out_state == ST_CLOSED);
  assign result.auto_mode_out = out_auto;

  // A relay pulse only ever accompanies a pulse state.
  a_pulse_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pulse |-> (out_state == ST_OPEN_PULSE) || (out_state == ST_CLOSE_PULSE))
    else $error("relay pulse outside a pulse state");

  // The shown result is the state the machine was left in.
  a_state_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> (ctx.state == out_state) && (ctx.auto_mode == out_auto))
    else $error("result does not match machine state");

  // The machine state only moves on a pass.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(ctx))
    else $error("machine state changed without a pass");

  // Once left, the initial state is never re-entered.
  a_no_init: assert property (@(posedge clk) disable iff (rst)
    (ctx.state != ST_INIT) |=> (ctx.state != ST_INIT))
    else $error("machine returned to the initial state");

endmodule
